>>> src/assert_macros.svh
// Assertion helpers for the accumulator block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication helper
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

>>> src/dmi_pta_pkg.sv
package dmi_pta_pkg;

	localparam int MaxNeighbours = 32;
	localparam int PairIndexBits = 20;
	localparam int CntCap = (MaxNeighbours > 63) ? 63 : MaxNeighbours;

	localparam logic [1:0] RegEnable = 2'd0;
	localparam logic [1:0] RegCutoff = 2'd1;
	localparam logic [1:0] RegThresh = 2'd2;

	typedef struct packed {
		logic signed [23:0] rij_x;
		logic signed [23:0] rij_y;
		logic signed [23:0] rij_z;
		logic signed [23:0] rik_x;
		logic signed [23:0] rik_y;
		logic signed [23:0] rik_z;
		logic signed [31:0] dmi_ik;
		logic signed [31:0] dmi_jk;
		logic [31:0]        inv_moment;
		logic               skip_item;
		logic               self_pair;
		logic               last_k;
	} in_item_t;

	typedef struct packed {
		logic [19:0]        pair_index;
		logic signed [47:0] tensor_xy;
		logic signed [47:0] tensor_zx;
		logic signed [47:0] tensor_yz;
		logic [5:0]         mediated_count;
	} out_item_t;

	// request to the divider: start strobe, numerator and denominator
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} div_req_t;

endpackage

>>> src/dmi_pta_div.sv
// Restoring divider, one quotient bit per cycle; also serves isqrt-free divides.
module dmi_pta_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dmi_pta_pkg::div_req_t req,
	output logic                 busy,
	output logic [63:0]          quot
);
	logic [63:0] rem_q, quo_q, den_q;
	logic [6:0]  cnt_q;
	logic [64:0] trial;

	assign trial = {rem_q[63:0], quo_q[63]} - {1'b0, den_q};
	assign busy  = (cnt_q != 7'd0);
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
		end else if (req.start) begin
			cnt_q <= 7'd64;
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy) begin
			cnt_q <= cnt_q - 7'd1;
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule

>>> src/dmi_pair_tensor_accumulator_top.sv
// DMI pair tensor accumulator.
// Input channel in_data/in_valid/in_ready carries one neighbour k of an i-j pair.
// Output channel out_data/out_valid/out_ready carries one tensor per pair,
// produced on the item flagged last_k.
// Registers over APB at byte addresses 0 enable, 8 squared cutoff, 16 zero threshold.
// Each item is processed by a sequencer around a shared 33x33 multiplier, a 16x32
// partial-product multiplier, a bit-serial square root unit and a 64-step divider.
// An item that is skipped, disabled, out of range or of zero length goes from the
// check straight to the emit step; an in-range item first takes two roots and six
// divides, then the cross products, the scale and the accumulate steps.
// in_ready is high only while the sequencer is idle.
// A result waits in the output register until taken; items keep flowing meanwhile,
// and the next last_k item holds in its final step until the register is free.
// Reset clears the sums, count, pair counter and registers to defaults.
module dmi_pair_tensor_accumulator_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dmi_pta_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dmi_pta_pkg::out_item_t out_data,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [63:0]            pwdata,
	output logic [63:0]            prdata,
	output logic                   pready
);
	typedef enum logic [4:0] {
		S_IDLE, S_SQ, S_CHK, S_RT_IK, S_RT_JK, S_DIV, S_DIVW, S_MUL,
		S_MULW, S_DIJ, S_SC, S_ACC, S_EMIT
	} state_t;

	state_t state_q;
	dmi_pta_pkg::in_item_t it_q;

	logic        en_q;
	logic [47:0] cut_q;
	logic [15:0] thr_q;
	logic signed [47:0] sxy_q, szx_q, syz_q;
	logic [5:0]  hit_q;
	logic [dmi_pta_pkg::PairIndexBits-1:0] pc_q;

	logic signed [24:0] vec_q [6];      // ik xyz, jk xyz
	logic [3:0]         idx_q;
	logic [51:0]        sqik_q, sqjk_q;
	logic [31:0]        lik_q, ljk_q;
	logic signed [32:0] unit_q [6];
	logic signed [63:0] dcr_q [3];
	logic [63:0]        dijm_q;

	// shared multiplier: 33x33 signed
	logic signed [32:0] ma, mb;
	logic signed [65:0] mp;
	logic signed [65:0] mp_s1;
	assign mp = ma * mb;

	// sqrt unit (bit-serial, 2 bits of radicand per step)
	logic [63:0] rt_x_q, rt_r_q, rt_b_q;
	logic [64:0] rt_t;
	assign rt_t = {1'b0, rt_x_q} - ({1'b0, rt_r_q} + {1'b0, rt_b_q});

	dmi_pta_pkg::div_req_t dreq;
	logic        dbusy;
	logic [63:0] dquot;
	dmi_pta_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .busy(dbusy), .quot(dquot));

	// APB
	logic wr;
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	always_comb begin
		unique case (paddr[4:3])
			dmi_pta_pkg::RegEnable: prdata = {63'd0, en_q};
			dmi_pta_pkg::RegCutoff: prdata = {16'd0, cut_q};
			dmi_pta_pkg::RegThresh: prdata = {48'd0, thr_q};
			default:   prdata = '0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	logic emit_go;
	assign emit_go = (state_q == S_EMIT) && it_q.last_k && (!out_valid || out_ready);

	logic [1:0] c3;
	logic [2:0] ua0, ua1, wb0, wb1;
	always_comb begin
		// cross product term indices for component c3 (0 x, 1 y, 2 z)
		unique case (c3)
			2'd0:    begin ua0 = 3'd1; wb0 = 3'd5; ua1 = 3'd2; wb1 = 3'd4; end
			2'd1:    begin ua0 = 3'd2; wb0 = 3'd3; ua1 = 3'd0; wb1 = 3'd5; end
			default: begin ua0 = 3'd0; wb0 = 3'd4; ua1 = 3'd1; wb1 = 3'd3; end
		endcase
	end
	assign c3 = idx_q[2:1];

	logic signed [63:0] dsel;
	assign dsel = (idx_q[1:0] == 2'd0) ? dcr_q[2] : (idx_q[1:0] == 2'd1) ? dcr_q[1] : dcr_q[0];

	logic signed [32:0] dsum;
	assign dsum = 33'(it_q.dmi_ik) + 33'(it_q.dmi_jk);

	// multiplier operand select
	always_comb begin
		ma = '0; mb = '0;
		unique case (state_q)
			S_SQ: begin ma = 33'(vec_q[idx_q[2:0]]); mb = 33'(vec_q[idx_q[2:0]]); end
			S_MUL: begin
				ma = idx_q[0] ? unit_q[ua1] : unit_q[ua0];
				mb = idx_q[0] ? unit_q[wb1] : unit_q[wb0];
			end
			S_DIJ: begin
				ma = dsum;
				mb = $signed({1'b0, it_q.inv_moment});
			end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	// scale: dijm (<=2^47) * |d| (<2^32) >> 22 via divider-free partials
	logic [31:0] dmag;
	assign dmag = dsel[63] ? 32'(-dsel) : 32'(dsel);
	logic [1:0]  sc_ph_q;
	logic [79:0] sc_acc_q;
	logic [15:0] mpart_a;
	logic [63:0] scp;
	assign mpart_a = sc_ph_q[1] ? 16'(dijm_q[47:32]) : sc_ph_q[0] ? dijm_q[31:16] : dijm_q[15:0];
	assign scp = 64'(mpart_a) * 64'(dmag);

	logic [47:0]        contrib;
	logic signed [47:0] sum_cur;
	logic signed [64:0] sum_ext;
	logic signed [47:0] sum_sat;
	always_comb begin
		contrib = (sc_acc_q[79:22] > 58'h7FFF_FFFF_FFFF) ? 48'h7FFF_FFFF_FFFF
		          : 48'(sc_acc_q[79:22]);
		sum_cur = (idx_q[1:0] == 2'd0) ? sxy_q : (idx_q[1:0] == 2'd1) ? szx_q : syz_q;
		// subtract when signs agree
		if (dsum[32] == dsel[63]) sum_ext = 65'(sum_cur) - $signed({17'd0, contrib});
		else sum_ext = 65'(sum_cur) + $signed({17'd0, contrib});
		if (sum_ext > 65'sh7FFF_FFFF_FFFF) sum_sat = 48'sh7FFF_FFFF_FFFF;
		else if (sum_ext < -65'sh8000_0000_0000) sum_sat = 48'sh8000_0000_0000;
		else sum_sat = 48'(sum_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			en_q <= 1'b0; cut_q <= 48'h1_0000_0000; thr_q <= 16'd1;
			sxy_q <= '0; szx_q <= '0; syz_q <= '0; hit_q <= '0; pc_q <= '0;
			out_valid <= 1'b0; dreq <= '0; idx_q <= '0;
		end else begin
			if (wr) begin
				unique case (paddr[4:3])
					dmi_pta_pkg::RegEnable: en_q  <= pwdata[0];
					dmi_pta_pkg::RegCutoff: cut_q <= pwdata[47:0];
					dmi_pta_pkg::RegThresh: thr_q <= pwdata[15:0];
					default: ;
				endcase
			end
			if (emit_go) out_valid <= 1'b1;
			else if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					it_q <= in_data;
					vec_q[0] <= 25'(in_data.rik_x);
					vec_q[1] <= 25'(in_data.rik_y);
					vec_q[2] <= 25'(in_data.rik_z);
					vec_q[3] <= 25'(in_data.rik_x) - 25'(in_data.rij_x);
					vec_q[4] <= 25'(in_data.rik_y) - 25'(in_data.rij_y);
					vec_q[5] <= 25'(in_data.rik_z) - 25'(in_data.rij_z);
					sqik_q <= '0; sqjk_q <= '0; idx_q <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (idx_q < 4'd3) sqik_q <= sqik_q + 52'(mp);
					else sqjk_q <= sqjk_q + 52'(mp);
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd5) state_q <= S_CHK;
				end
				S_CHK: begin
					if (en_q && !it_q.skip_item && !it_q.self_pair &&
					    {4'd0, cut_q} >= sqik_q && {4'd0, cut_q} >= sqjk_q) begin
						if (hit_q < 6'(dmi_pta_pkg::CntCap)) hit_q <= hit_q + 6'd1;
						if (sqik_q != 0 && sqjk_q != 0) begin
							rt_x_q <= 64'(sqik_q); rt_r_q <= '0; rt_b_q <= 64'd1 << 52;
							state_q <= S_RT_IK;
						end else state_q <= S_EMIT;
					end else state_q <= S_EMIT;
				end
				S_RT_IK, S_RT_JK: begin
					if (rt_b_q == 0) begin
						if (state_q == S_RT_IK) begin
							lik_q <= 32'(rt_r_q);
							rt_x_q <= 64'(sqjk_q); rt_r_q <= '0; rt_b_q <= 64'd1 << 52;
							state_q <= S_RT_JK;
						end else begin
							ljk_q <= 32'(rt_r_q); idx_q <= '0; state_q <= S_DIV;
						end
					end else begin
						if (!rt_t[64]) begin
							rt_x_q <= rt_t[63:0];
							rt_r_q <= (rt_r_q >> 1) + rt_b_q;
						end else rt_r_q <= rt_r_q >> 1;
						rt_b_q <= rt_b_q >> 2;
					end
				end
				S_DIV: begin
					dreq.start <= 1'b1;
					dreq.num <= 64'(vec_q[idx_q[2:0]][24] ? -vec_q[idx_q[2:0]] : vec_q[idx_q[2:0]]) << 30;
					dreq.den <= (idx_q < 4'd3) ? 64'(lik_q) : 64'(ljk_q);
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					dreq.start <= 1'b0;
					if (!dreq.start && !dbusy) begin
						unit_q[idx_q[2:0]] <= vec_q[idx_q[2:0]][24] ? -33'(dquot) : 33'(dquot);
						if (idx_q == 4'd5) begin
							idx_q <= '0; state_q <= S_MUL;
						end else begin
							idx_q <= idx_q + 4'd1; state_q <= S_DIV;
						end
					end
				end
				S_MUL: begin mp_s1 <= mp; state_q <= S_MULW; end
				S_MULW: begin
					if (!idx_q[0]) dcr_q[c3] <= 64'(mp_s1);
					else dcr_q[c3] <= (dcr_q[c3] - 64'(mp_s1)) >>> 30;
					idx_q <= idx_q + 4'd1;
					if (idx_q == 4'd5) state_q <= S_DIJ; else state_q <= S_MUL;
				end
				S_DIJ: begin
					dijm_q <= (mp[65] ? 64'(-mp) : 64'(mp)) >> 17;
					idx_q <= '0; sc_ph_q <= '0; sc_acc_q <= '0;
					state_q <= S_SC;
				end
				S_SC: begin
					sc_acc_q <= sc_acc_q + (80'(scp) << (16 * sc_ph_q));
					if (sc_ph_q == 2'd2) state_q <= S_ACC; else sc_ph_q <= sc_ph_q + 2'd1;
				end
				S_ACC: begin
					unique case (idx_q[1:0])
						2'd0: sxy_q <= sum_sat;
						2'd1: szx_q <= sum_sat;
						default: syz_q <= sum_sat;
					endcase
					sc_ph_q <= '0; sc_acc_q <= '0;
					idx_q <= idx_q + 4'd1;
					if (idx_q[1:0] == 2'd2) state_q <= S_EMIT; else state_q <= S_SC;
				end
				S_EMIT: begin
					if (!it_q.last_k) begin
						state_q <= S_IDLE;
					end else if (emit_go) begin
						out_data.pair_index <= 20'(pc_q);
						out_data.tensor_xy <= (en_q && (sxy_q[47] ? 48'(-sxy_q) : sxy_q)
							>= 48'(thr_q)) ? sxy_q : '0;
						out_data.tensor_zx <= (en_q && (szx_q[47] ? 48'(-szx_q) : szx_q)
							>= 48'(thr_q)) ? szx_q : '0;
						out_data.tensor_yz <= (en_q && (syz_q[47] ? 48'(-syz_q) : syz_q)
							>= 48'(thr_q)) ? syz_q : '0;
						out_data.mediated_count <= en_q ? hit_q : '0;
						pc_q <= pc_q + {{(dmi_pta_pkg::PairIndexBits-1){1'b0}}, 1'b1};
						sxy_q <= '0; szx_q <= '0; syz_q <= '0; hit_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> src/dmi_pta_checker.sv
`include "assert_macros.svh"
module dmi_pta_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input dmi_pta_pkg::out_item_t out_data,
	input logic pready
);
	`ASSERT_CLK(a_pready, clk, arst_n, pready, "pready low")
	`ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready, ##1 out_valid, "out dropped")
	`ASSERT_IMPL(a_out_stable, clk, arst_n, out_valid && !out_ready, ##1 $stable(out_data), "out changed")
	`ASSERT_IMPL(a_busy, clk, arst_n, in_valid && in_ready, ##1 !in_ready, "ready after transfer")
endmodule

bind dmi_pair_tensor_accumulator_top dmi_pta_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .pready(pready)
);
